/* sv/stc_pkg.sv */
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants for temperature compensation
// Field widths, calibration reset values, register codes and the
// divider request/response structs.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int RAW_W    = 16;
  localparam int CAL_W    = 16;
  localparam int SHIFT_X1 = 15;
  localparam int SHIFT_MC = 11;
  localparam int ROUND_T  = 8;
  localparam int DIV_T    = 1 << 4;
  localparam int DIV_T_SH = $clog2(DIV_T);

  // (raw - c6) is 17 bit signed, c5 widened to 17 bit signed
  localparam int DIFF_W = RAW_W + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int X1_W   = PROD_W - SHIFT_X1;
  localparam int DIV_W  = X1_W + 1;
  localparam int NUM_W  = CAL_W + SHIFT_MC;
  localparam int B5_W   = 28;
  localparam int TEMP_W = 24;
  localparam int SUM_W  = B5_W + 1;

  localparam int DIV_STAGES = NUM_W;
  localparam int ACC_W      = DIV_W + NUM_W;

  localparam int CFG_IDX_W = 2;

  localparam logic        [CAL_W-1:0] CAL_C5_RST = 16'd32757;
  localparam logic        [CAL_W-1:0] CAL_C6_RST = 16'd23153;
  localparam logic signed [CAL_W-1:0] CAL_MC_RST = -16'sd8711;
  localparam logic signed [CAL_W-1:0] CAL_MD_RST = 16'sd2868;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_C5 = 2'd0,
    CFG_C6 = 2'd1,
    CFG_MC = 2'd2,
    CFG_MD = 2'd3
  } stc_cfg_idx_t;

  typedef struct packed {
    logic        [NUM_W-1:0] dvd;
    logic        [DIV_W-1:0] dvs;
    logic signed [X1_W-1:0]  x1;
    logic                    neg_q;
    logic                    dz;
  } stc_div_req_t;

  typedef struct packed {
    logic        [NUM_W-1:0] quo;
    logic signed [X1_W-1:0]  x1;
    logic                    neg_q;
    logic                    dz;
  } stc_div_rsp_t;

endpackage

/* sv/stc_if.sv */
// ----------------------------------------------------------------------------
// stc_if: item channels of the temperature compensation block
// Valid/ready channels for the raw reading and the compensated result.
// ----------------------------------------------------------------------------
interface stc_in_if import stc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_temperature;

  modport source (output valid, output raw_temperature, input ready);
  modport sink   (input valid, input raw_temperature, output ready);
endinterface

interface stc_out_if import stc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TEMP_W-1:0] temperature_tenths;
  logic signed [B5_W-1:0]   b5_value;
  logic                     divide_by_zero;

  modport source (output valid, output temperature_tenths, output b5_value,
                  output divide_by_zero, input ready);
  modport sink   (input valid, input temperature_tenths, input b5_value,
                  input divide_by_zero, output ready);
endinterface

/* sv/stc_div_pipe.sv */
// ----------------------------------------------------------------------------
// stc_div_pipe: pipelined unsigned restoring divider
// One quotient bit per stage, elastic valid/ready between stages,
// sideband fields travel with each item.
// ----------------------------------------------------------------------------
module stc_div_pipe import stc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_ready,
  input  stc_div_req_t in_req,
  output logic         out_valid,
  input  logic         out_ready,
  output stc_div_rsp_t out_rsp
);

  logic [DIV_STAGES-1:0]   vld_r;
  logic [DIV_STAGES:0]     rdy;
  logic [ACC_W-1:0]        acc_r   [DIV_STAGES];
  logic [DIV_W-1:0]        dvs_r   [DIV_STAGES];
  logic signed [X1_W-1:0]  x1_r    [DIV_STAGES];
  logic [DIV_STAGES-1:0]   neg_r;
  logic [DIV_STAGES-1:0]   dz_r;

  logic [DIV_STAGES-1:0]   vld_in;
  logic [ACC_W-1:0]        acc_in  [DIV_STAGES];
  logic [DIV_W-1:0]        dvs_in  [DIV_STAGES];
  logic signed [X1_W-1:0]  x1_in   [DIV_STAGES];
  logic [DIV_STAGES-1:0]   neg_in;
  logic [DIV_STAGES-1:0]   dz_in;
  logic [ACC_W-1:0]        acc_nxt [DIV_STAGES];

  // stage inputs: first stage from the request, others from the previous stage
  always_comb begin
    vld_in[0] = in_valid;
    acc_in[0] = {{DIV_W{1'b0}}, in_req.dvd};
    dvs_in[0] = in_req.dvs;
    x1_in[0]  = in_req.x1;
    neg_in[0] = in_req.neg_q;
    dz_in[0]  = in_req.dz;
    for (int k = 1; k < DIV_STAGES; k++) begin
      vld_in[k] = vld_r[k-1];
      acc_in[k] = acc_r[k-1];
      dvs_in[k] = dvs_r[k-1];
      x1_in[k]  = x1_r[k-1];
      neg_in[k] = neg_r[k-1];
      dz_in[k]  = dz_r[k-1];
    end
  end

  // shift in the next dividend bit, subtract the divisor when it fits
  always_comb begin
    logic [DIV_W:0] cand;
    logic [DIV_W:0] diff;
    for (int k = 0; k < DIV_STAGES; k++) begin
      cand = acc_in[k][ACC_W-1 -: DIV_W+1];
      diff = cand - {1'b0, dvs_in[k]};
      if (cand >= {1'b0, dvs_in[k]}) begin
        acc_nxt[k] = {diff[DIV_W-1:0], acc_in[k][NUM_W-2:0], 1'b1};
      end else begin
        acc_nxt[k] = {acc_in[k][ACC_W-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    rdy[DIV_STAGES] = out_ready;
    for (int k = DIV_STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_in[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      if (rdy[k] && vld_in[k]) begin
        acc_r[k] <= acc_nxt[k];
        dvs_r[k] <= dvs_in[k];
        x1_r[k]  <= x1_in[k];
        neg_r[k] <= neg_in[k];
        dz_r[k]  <= dz_in[k];
      end
    end
  end

  assign in_ready      = rdy[0];
  assign out_valid     = vld_r[DIV_STAGES-1];
  assign out_rsp.quo   = acc_r[DIV_STAGES-1][NUM_W-1:0];
  assign out_rsp.x1    = x1_r[DIV_STAGES-1];
  assign out_rsp.neg_q = neg_r[DIV_STAGES-1];
  assign out_rsp.dz    = dz_r[DIV_STAGES-1];

  a_rem_below_dvs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (dvs_r[DIV_STAGES-1] != '0) |->
      (acc_r[DIV_STAGES-1][ACC_W-1 -: DIV_W] < dvs_r[DIV_STAGES-1]))
    else $error("divider remainder not below divisor");

  a_no_stall_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("divider refuses an item while its output drains");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] && !rdy[1] |=> vld_r[0] && $stable(acc_r[0]))
    else $error("stalled divider stage lost its item");

endmodule

/* sv/sensor_temperature_compensation_top.sv */
// ----------------------------------------------------------------------------
// sensor_temperature_compensation_top: barometric sensor temperature path
// Raw reading plus four calibration words in, compensated temperature in
// tenths of a degree and the B5 intermediate out.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake     | payload
//  ---------+-----+---------------+---------------------------------------------
//  in_chan  | in  | valid/ready   | raw_temperature (16 u)
//  out_chan | out | valid/ready   | temperature_tenths (24 s), b5_value (28 s),
//           |     |               | divide_by_zero (1)
//  cfg_*    | in  | cfg_we strobe | cfg_index (2), cfg_wdata (16)
//
//  One item per cycle while the output is not stalled; the divider resolves
//  one quotient bit per stage (27 stages), and five more stages handle the
//  multiply, X1, operand signs, B5 and the final rounding.
//  Reset (rst_n low, synchronous) clears all stage valid bits and restores
//  the calibration registers; data registers are not reset.
//  Every stage holds its item while the next one is full and stalled, and
//  takes a new item whenever it is empty, so bubbles squeeze out on stalls.
// ----------------------------------------------------------------------------
module sensor_temperature_compensation_top import stc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  stc_in_if.sink               in_chan,
  stc_out_if.source            out_chan,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CAL_W-1:0]     cfg_wdata
);

  localparam int PIPE_DEPTH = DIV_STAGES + 5;
  localparam int OCC_W      = $clog2(PIPE_DEPTH + 1);

  // calibration registers
  logic        [CAL_W-1:0] cal_c5_r;
  logic        [CAL_W-1:0] cal_c6_r;
  logic signed [CAL_W-1:0] cal_mc_r;
  logic signed [CAL_W-1:0] cal_md_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_c5_r <= CAL_C5_RST;
      cal_c6_r <= CAL_C6_RST;
      cal_mc_r <= CAL_MC_RST;
      cal_md_r <= CAL_MD_RST;
    end else if (cfg_we) begin
      unique case (stc_cfg_idx_t'(cfg_index))
        CFG_C5: cal_c5_r <= cfg_wdata;
        CFG_C6: cal_c6_r <= cfg_wdata;
        CFG_MC: cal_mc_r <= signed'(cfg_wdata);
        CFG_MD: cal_md_r <= signed'(cfg_wdata);
      endcase
    end
  end

  // stage valid bits and per-stage ready
  logic vld1_r, vld2_r, vld3_r, vld4_r, vld5_r;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic div_in_ready;
  logic div_out_valid;

  assign rdy5 = !vld5_r || out_chan.ready;
  assign rdy4 = !vld4_r || rdy5;
  assign rdy3 = !vld3_r || div_in_ready;
  assign rdy2 = !vld2_r || rdy3;
  assign rdy1 = !vld1_r || rdy2;

  assign in_chan.ready = rdy1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
    end else begin
      if (rdy1) vld1_r <= in_chan.valid;
      if (rdy2) vld2_r <= vld1_r;
      if (rdy3) vld3_r <= vld2_r;
      if (rdy4) vld4_r <= div_out_valid;
      if (rdy5) vld5_r <= vld4_r;
    end
  end

  // stage 1: offset the reading and scale by c5, exact 34-bit product
  logic signed [DIFF_W-1:0] diff_s;
  logic signed [DIFF_W-1:0] c5_s;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;

  always_comb begin
    diff_s   = signed'({1'b0, in_chan.raw_temperature}) - signed'({1'b0, cal_c6_r});
    c5_s     = signed'({1'b0, cal_c5_r});
    prod_nxt = PROD_W'(diff_s) * PROD_W'(c5_s);
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_chan.valid) prod_r <= prod_nxt;
  end

  // stage 2: arithmetic shift gives floor, then form the divisor
  logic signed [X1_W-1:0]  x1_nxt;
  logic signed [DIV_W-1:0] div_nxt;
  logic signed [X1_W-1:0]  x1_r;
  logic signed [DIV_W-1:0] div_r;

  always_comb begin
    x1_nxt  = signed'(prod_r[PROD_W-1:SHIFT_X1]);
    div_nxt = DIV_W'(x1_nxt) + DIV_W'(cal_md_r);
  end

  always_ff @(posedge clk) begin
    if (rdy2 && vld1_r) begin
      x1_r  <= x1_nxt;
      div_r <= div_nxt;
    end
  end

  // stage 3: split numerator and divisor into sign and magnitude
  logic signed [NUM_W-1:0] num_s;
  stc_div_req_t            req_nxt;
  stc_div_req_t            req_r;

  always_comb begin
    num_s         = signed'({cal_mc_r, {SHIFT_MC{1'b0}}});
    req_nxt.dvd   = num_s[NUM_W-1] ? NUM_W'(-num_s) : NUM_W'(num_s);
    req_nxt.dvs   = div_r[DIV_W-1] ? DIV_W'(-div_r) : DIV_W'(div_r);
    req_nxt.x1    = x1_r;
    req_nxt.neg_q = num_s[NUM_W-1] ^ div_r[DIV_W-1];
    req_nxt.dz    = (div_r == '0);
  end

  always_ff @(posedge clk) begin
    if (rdy3 && vld2_r) req_r <= req_nxt;
  end

  stc_div_rsp_t div_rsp;

  stc_div_pipe u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (vld3_r),
    .in_ready  (div_in_ready),
    .in_req    (req_r),
    .out_valid (div_out_valid),
    .out_ready (rdy4),
    .out_rsp   (div_rsp)
  );

  // stage 4: restore the quotient sign, B5 = X1 + X2, zero on a zero divisor
  logic signed [B5_W-1:0] x2_s;
  logic signed [B5_W-1:0] b5_nxt;
  logic signed [B5_W-1:0] b5_r;
  logic                   dz4_r;

  always_comb begin
    x2_s   = div_rsp.neg_q ? -B5_W'(div_rsp.quo) : B5_W'(div_rsp.quo);
    b5_nxt = div_rsp.dz ? '0 : B5_W'(div_rsp.x1) + x2_s;
  end

  always_ff @(posedge clk) begin
    if (rdy4 && div_out_valid) begin
      b5_r  <= b5_nxt;
      dz4_r <= div_rsp.dz;
    end
  end

  // stage 5: (B5 + 8) / 16 toward zero; bias negatives before the shift
  logic signed [SUM_W-1:0]  sum_s;
  logic signed [SUM_W-1:0]  adj_s;
  logic signed [TEMP_W-1:0] temp_nxt;
  logic signed [TEMP_W-1:0] temp_r;
  logic signed [B5_W-1:0]   b5o_r;
  logic                     dz5_r;

  always_comb begin
    sum_s    = SUM_W'(b5_r) + SUM_W'(ROUND_T);
    adj_s    = sum_s[SUM_W-1] ? sum_s + SUM_W'(DIV_T - 1) : sum_s;
    temp_nxt = signed'(adj_s[TEMP_W+DIV_T_SH-1:DIV_T_SH]);
  end

  always_ff @(posedge clk) begin
    if (rdy5 && vld4_r) begin
      temp_r <= temp_nxt;
      b5o_r  <= b5_r;
      dz5_r  <= dz4_r;
    end
  end

  assign out_chan.valid              = vld5_r;
  assign out_chan.temperature_tenths = temp_r;
  assign out_chan.b5_value           = b5o_r;
  assign out_chan.divide_by_zero     = dz5_r;

  // items in flight, for checking only
  logic             in_acc;
  logic             out_acc;
  logic [OCC_W-1:0] occ_r;

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_chan.valid && out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + OCC_W'(in_acc) - OCC_W'(out_acc);
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(PIPE_DEPTH))
    else $error("more items in flight than pipeline stages");

  a_out_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> occ_r != '0)
    else $error("result shown with no item in flight");

  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.divide_by_zero |->
      (out_chan.temperature_tenths == '0) && (out_chan.b5_value == '0))
    else $error("zero divisor result not forced to zero");

  a_drain_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.ready |-> in_chan.ready)
    else $error("input refused while the output drains");

endmodule
